// ===== sv/ctgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctgb_pkg
// Shared field widths, operation codes and status codes of the gap buffer.
// ----------------------------------------------------------------------------
package ctgb_pkg;

  localparam int OpW     = 3;
  localparam int CharW   = 8;
  localparam int IndexW  = 12;
  localparam int StatusW = 2;
  localparam int OutCntW = 13;

  typedef enum logic [OpW-1:0] {
    OP_LEFT   = 3'd0,
    OP_RIGHT  = 3'd1,
    OP_BACK   = 3'd2,
    OP_INSERT = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_DONE     = 2'd0,
    STAT_BOUNDARY = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_RANGE    = 2'd3
  } status_e;

endpackage

// ===== sv/ctgb_stack_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctgb_stack_ram
// One-write, one-read synchronous memory holding one character stack.
// ----------------------------------------------------------------------------
module ctgb_stack_ram #(
  parameter int Depth = 4096,
  parameter int AddrW = 12
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [ctgb_pkg::CharW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [ctgb_pkg::CharW-1:0] rdata_o
);
  import ctgb_pkg::*;

  logic [CharW-1:0] mem [Depth];
  logic [CharW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cursor_text_gap_buffer.sv =====
`timescale 1ns / 1ps
// Backspace, insert and refused operations give their result in the cycle after
// the input transfer; moves and reads pass through a wait state for the registered
// read port of a stack memory and finish there once the result register is free.
// No new operation is taken while one waits there or while a stalled result is held.
// Reset: both counts clear, so the text is empty; memory contents are left as
// they are and only entries below the counts are ever read.
// ----------------------------------------------------------------------------
// cursor_text_gap_buffer
// Line-edit buffer with a cursor, held as a left stack and a right stack.
// ----------------------------------------------------------------------------
module cursor_text_gap_buffer #(
  parameter int CAPACITY = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ctgb_pkg::OpW-1:0]      operation_i,
  input  logic [ctgb_pkg::CharW-1:0]    char_in_i,
  input  logic [ctgb_pkg::IndexW-1:0]   read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ctgb_pkg::StatusW-1:0]  status_o,
  output logic [ctgb_pkg::CharW-1:0]    char_out_o,
  output logic [ctgb_pkg::OutCntW-1:0]  text_length_o,
  output logic [ctgb_pkg::OutCntW-1:0]  cursor_pos_o
);
  import ctgb_pkg::*;

  // Count width holds CAPACITY itself; address width indexes the stacks.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // Compare width wide enough for both the read index and any length.
  localparam int XW = ((CW > IndexW) ? CW : IndexW) + 1;

  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [CW:0]   CapL = (CW + 1)'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_e;

  // What the wait state of a move or read must finish.
  typedef enum logic [1:0] {
    P_MOVE_L,
    P_MOVE_R,
    P_READ_L,
    P_READ_R
  } pend_e;

  state_e          state_q, state_d;
  pend_e           pend_q, pend_d;
  logic [CW-1:0]   lc_q, lc_d;
  logic [CW-1:0]   rc_q, rc_d;
  logic [AW-1:0]   waddr_q, waddr_d;

  logic                out_valid_q;
  logic [StatusW-1:0]  status_q;
  logic [CharW-1:0]    char_q;
  logic [OutCntW-1:0]  len_out_q;
  logic [OutCntW-1:0]  cur_out_q;

  logic                res_load;
  status_e             res_status;
  logic [CharW-1:0]    res_char;

  logic                l_we, l_re, r_we, r_re;
  logic [AW-1:0]       l_waddr, l_raddr, r_waddr, r_raddr;
  logic [CharW-1:0]    l_wdata, r_wdata, l_rdata, r_rdata;

  logic                out_free;
  logic                accept;
  op_e                 op;
  logic [CW:0]         len;
  logic [CW:0]         len_d;
  logic [XW-1:0]       idx_x, lc_x, len_x;

  // The result register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign op    = op_e'(operation_i);
  assign len   = (CW + 1)'(lc_q) + (CW + 1)'(rc_q);
  assign len_d = (CW + 1)'(lc_d) + (CW + 1)'(rc_d);
  assign idx_x = XW'(read_index_i);
  assign lc_x  = XW'(lc_q);
  assign len_x = XW'(len);

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    lc_d       = lc_q;
    rc_d       = rc_q;
    waddr_d    = waddr_q;
    res_load   = 1'b0;
    res_status = STAT_BOUNDARY;
    res_char   = '0;
    l_we       = 1'b0;
    l_waddr    = AW'(lc_q);
    l_wdata    = char_in_i;
    l_re       = 1'b0;
    l_raddr    = AW'(idx_x);
    r_we       = 1'b0;
    r_waddr    = waddr_q;
    r_wdata    = l_rdata;
    r_re       = 1'b0;
    r_raddr    = AW'(len_x - XW'(1) - idx_x);

    if (state_q == S_IDLE) begin
      if (accept) begin
        case (op)
          OP_LEFT: begin
            // Pop the left top now, push it on the right once the data returns.
            if ((lc_q != '0) && (rc_q < CapC)) begin
              lc_d    = lc_q - CW'(1);
              rc_d    = rc_q + CW'(1);
              l_re    = 1'b1;
              l_raddr = AW'(lc_q - CW'(1));
              waddr_d = AW'(rc_q);
              pend_d  = P_MOVE_L;
              state_d = S_WAIT;
            end else begin
              res_load = 1'b1;
            end
          end
          OP_RIGHT: begin
            if ((rc_q != '0) && (lc_q < CapC)) begin
              rc_d    = rc_q - CW'(1);
              lc_d    = lc_q + CW'(1);
              r_re    = 1'b1;
              r_raddr = AW'(rc_q - CW'(1));
              waddr_d = AW'(lc_q);
              pend_d  = P_MOVE_R;
              state_d = S_WAIT;
            end else begin
              res_load = 1'b1;
            end
          end
          OP_BACK: begin
            res_load = 1'b1;
            if (lc_q != '0) begin
              lc_d       = lc_q - CW'(1);
              res_status = STAT_DONE;
            end
          end
          OP_INSERT: begin
            res_load = 1'b1;
            if (len >= CapL) begin
              res_status = STAT_FULL;
            end else begin
              l_we       = 1'b1;
              lc_d       = lc_q + CW'(1);
              res_status = STAT_DONE;
            end
          end
          OP_READ: begin
            // Positions below the cursor sit in the left stack bottom-up,
            // the rest in the right stack top-down.
            if (idx_x < lc_x) begin
              l_re    = 1'b1;
              pend_d  = P_READ_L;
              state_d = S_WAIT;
            end else if (idx_x < len_x) begin
              r_re    = 1'b1;
              pend_d  = P_READ_R;
              state_d = S_WAIT;
            end else begin
              res_load   = 1'b1;
              res_status = STAT_RANGE;
            end
          end
          default: begin
            res_load = 1'b1;
          end
        endcase
      end
    end else begin
      // Finish the pending operation only when its result can be held.
      if (out_free) begin
        res_load   = 1'b1;
        res_status = STAT_DONE;
        state_d    = S_IDLE;
        case (pend_q)
          P_MOVE_L: begin
            r_we    = 1'b1;
            r_waddr = waddr_q;
            r_wdata = l_rdata;
          end
          P_MOVE_R: begin
            l_we    = 1'b1;
            l_waddr = waddr_q;
            l_wdata = r_rdata;
          end
          P_READ_L: begin
            res_char = l_rdata;
          end
          P_READ_R: begin
            res_char = r_rdata;
          end
          default: begin
            res_char = '0;
          end
        endcase
      end
    end
  end

  ctgb_stack_ram #(
    .Depth (CAPACITY),
    .AddrW (AW)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  ctgb_stack_ram #(
    .Depth (CAPACITY),
    .AddrW (AW)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .re_i    (r_re),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  // Control state, counts and the result register; hold the result payload
  // until the downstream transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= P_READ_L;
      lc_q        <= '0;
      rc_q        <= '0;
      waddr_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      char_q      <= '0;
      len_out_q   <= '0;
      cur_out_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      lc_q    <= lc_d;
      rc_q    <= rc_d;
      waddr_q <= waddr_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
        status_q    <= res_status;
        char_q      <= res_char;
        len_out_q   <= OutCntW'(32'(len_d));
        cur_out_q   <= OutCntW'(32'(lc_d));
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign char_out_o    = char_q;
  assign text_length_o = len_out_q;
  assign cursor_pos_o  = cur_out_q;

endmodule

// ===== sim/cursor_text_gap_buffer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_text_gap_buffer_test
// Self-checking bench for the cursor gap buffer. A table of hand-picked edits
// runs first, then random editing with typed words read back by index, a few
// probes around the cursor and a closing stretch at full rate. An internal
// model of the two stacks predicts every result, and each output transfer is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cursor_text_gap_buffer_test;
  import ctgb_pkg::*;

  localparam int Cap        = 4096;
  localparam int ClkHalf    = 10;
  localparam int ResetCyc   = 6;
  localparam int RandomOps  = 430;
  localparam int FinalOps   = 80;
  localparam int CycleLimit = 600000;
  localparam int ShowFails  = 10;

  // Operation codes that the block must refuse.
  localparam logic [OpW-1:0] OpSpare5 = 3'd5;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  typedef struct packed {
    status_e              status;
    logic [CharW-1:0]     ch;
    logic [OutCntW-1:0]   len;
    logic [OutCntW-1:0]   cur;
  } edit_result_t;

  typedef struct packed {
    logic [OpW-1:0]       op;
    logic [CharW-1:0]     ch;
    logic [IndexW-1:0]    idx;
    bit                   typed;
    edit_result_t         res;
  } stim_row_t;

  // Clock, reset and the driven side of both channels; all known from time 0.
  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 in_valid   = 1'b0;
  logic [OpW-1:0]       op_drv     = OP_LEFT;
  logic [CharW-1:0]     char_drv   = '0;
  logic [IndexW-1:0]    index_drv  = '0;
  logic                 out_stall  = 1'b0;

  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [StatusW-1:0]   status_o;
  logic [CharW-1:0]     char_out_o;
  logic [OutCntW-1:0]   text_length_o;
  logic [OutCntW-1:0]   cursor_pos_o;

  // Model of the text: characters left of the cursor from the start of the
  // line, characters right of it with the one next to the cursor on top.
  logic [CharW-1:0]     left_text  [Cap];
  logic [CharW-1:0]     right_text [Cap];
  int unsigned          left_n  = 0;
  int unsigned          right_n = 0;

  edit_result_t         pending_results [$];
  int                   fail_count  = 0;
  int                   cycle_count = 0;
  bit                   idle_on     = 1'b1;
  int                   stall_run   = 0;

  cursor_text_gap_buffer #(
    .CAPACITY      (Cap)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .operation_i   (op_drv),
    .char_in_i     (char_drv),
    .read_index_i  (index_drv),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .status_o      (status_o),
    .char_out_o    (char_out_o),
    .text_length_o (text_length_o),
    .cursor_pos_o  (cursor_pos_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Give up on a hung block: a correct run ends far below this count.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("[cursor_text_gap_buffer] ERROR");
    $finish;
  end

  // Apply one edit to the model and return what the block must report.
  function automatic edit_result_t predict_edit(input logic [OpW-1:0] op,
                                                input logic [CharW-1:0] ch,
                                                input logic [IndexW-1:0] idx);
    edit_result_t r;
    int unsigned  len;
    len      = left_n + right_n;
    r.status = STAT_BOUNDARY;
    r.ch     = '0;
    case (op)
      OP_LEFT: begin
        if (left_n > 0 && right_n < Cap) begin
          left_n--;
          right_text[right_n] = left_text[left_n];
          right_n++;
          r.status = STAT_DONE;
        end
      end
      OP_RIGHT: begin
        if (right_n > 0 && left_n < Cap) begin
          right_n--;
          left_text[left_n] = right_text[right_n];
          left_n++;
          r.status = STAT_DONE;
        end
      end
      OP_BACK: begin
        if (left_n > 0) begin
          left_n--;
          r.status = STAT_DONE;
        end
      end
      OP_INSERT: begin
        if (len >= Cap) begin
          r.status = STAT_FULL;
        end else begin
          left_text[left_n] = ch;
          left_n++;
          r.status = STAT_DONE;
        end
      end
      OP_READ: begin
        // Positions below the cursor sit in the left stack in order; the rest
        // count down from the top of the right stack.
        if (idx < left_n) begin
          r.ch     = left_text[idx];
          r.status = STAT_DONE;
        end else if (idx < len) begin
          r.ch     = right_text[right_n - 1 - (idx - left_n)];
          r.status = STAT_DONE;
        end else begin
          r.status = STAT_RANGE;
        end
      end
      default: ;
    endcase
    r.len = OutCntW'(left_n + right_n);
    r.cur = OutCntW'(left_n);
    return r;
  endfunction

  // Offer one edit from a falling edge, hold it until the transfer and log
  // the expected result. Returns on the next falling edge with valid still
  // high, so a following call carries straight on without a bubble.
  task automatic apply_edit(input logic [OpW-1:0] op, input logic [CharW-1:0] ch,
                            input logic [IndexW-1:0] idx, input bit typed = 1'b0,
                            input edit_result_t typed_res = '0);
    edit_result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    op_drv    <= op;
    char_drv  <= ch;
    index_drv <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_edit(op, ch, idx);
    // Rows with a hand-written answer are checked against that answer; the
    // model still advances so later predictions stay in step.
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every logged result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One random edit, weighted towards typing and reading inside the text.
  task automatic random_edit();
    int unsigned      pick;
    int unsigned      len;
    logic [OpW-1:0]   op;
    logic [IndexW-1:0] idx;
    pick = $urandom_range(0, 99);
    len  = left_n + right_n;
    idx  = IndexW'($urandom_range(0, (1 << IndexW) - 1));
    if (pick < 34)      op = OP_INSERT;
    else if (pick < 46) op = OP_LEFT;
    else if (pick < 58) op = OP_RIGHT;
    else if (pick < 70) op = OP_BACK;
    else if (pick < 95) op = OP_READ;
    else                op = OpW'($urandom_range(OpSpare5, OpSpare7));
    // Most reads land inside the text; the rest go anywhere in the index range.
    if (op == OP_READ && len > 0 && $urandom_range(0, 4) != 0)
      idx = IndexW'($urandom_range(0, len - 1));
    apply_edit(op, CharW'($urandom_range(0, 255)), idx);
  endtask

  // Output side: stall in random bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_run <= $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each output transfer with the oldest outstanding prediction.
  always @(posedge clk_i) begin
    edit_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= ShowFails)
          $display("%0t: result with nothing outstanding: status %0d char %02h len %0d cur %0d",
                   $realtime, status_o, char_out_o, text_length_o, cursor_pos_o);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || char_out_o !== want.ch ||
            text_length_o !== want.len || cursor_pos_o !== want.cur) begin
          fail_count++;
          if (fail_count <= ShowFails)
            $display("%0t: mismatch: status %0d/%0d char %02h/%02h len %0d/%0d cur %0d/%0d %s",
                     $realtime, status_o, want.status, char_out_o, want.ch,
                     text_length_o, want.len, cursor_pos_o, want.cur,
                     "(actual/expected)");
        end
      end
    end
  end

  // Hand-picked opening: every refusal on an empty line, both extremes of the
  // character and the index, crossing the cursor both ways, reading from
  // either side of it, and the spare operation codes.
  stim_row_t directed_rows [25] = '{
    '{OP_LEFT,   8'h00, 12'h000, 1'b1, '{STAT_BOUNDARY, 8'h00, 13'd0, 13'd0}},
    '{OP_RIGHT,  8'h00, 12'h000, 1'b1, '{STAT_BOUNDARY, 8'h00, 13'd0, 13'd0}},
    '{OP_BACK,   8'h00, 12'h000, 1'b1, '{STAT_BOUNDARY, 8'h00, 13'd0, 13'd0}},
    '{OP_READ,   8'h00, 12'h000, 1'b1, '{STAT_RANGE,    8'h00, 13'd0, 13'd0}},
    '{OP_READ,   8'hFF, 12'hFFF, 1'b1, '{STAT_RANGE,    8'h00, 13'd0, 13'd0}},
    '{OpSpare5,  8'hFF, 12'hFFF, 1'b1, '{STAT_BOUNDARY, 8'h00, 13'd0, 13'd0}},
    '{OpSpare5 + 3'd1, 8'h00, 12'h000, 1'b1, '{STAT_BOUNDARY, 8'h00, 13'd0, 13'd0}},
    '{OpSpare7,  8'h00, 12'h000, 1'b1, '{STAT_BOUNDARY, 8'h00, 13'd0, 13'd0}},
    '{OP_INSERT, 8'h00, 12'hFFF, 1'b1, '{STAT_DONE,     8'h00, 13'd1, 13'd1}},
    '{OP_INSERT, 8'hFF, 12'h000, 1'b1, '{STAT_DONE,     8'h00, 13'd2, 13'd2}},
    '{OP_READ,   8'hFF, 12'h000, 1'b1, '{STAT_DONE,     8'h00, 13'd2, 13'd2}},
    '{OP_READ,   8'h00, 12'h001, 1'b1, '{STAT_DONE,     8'hFF, 13'd2, 13'd2}},
    '{OP_READ,   8'h00, 12'h002, 1'b1, '{STAT_RANGE,    8'h00, 13'd2, 13'd2}},
    '{OP_LEFT,   8'h00, 12'h000, 1'b1, '{STAT_DONE,     8'h00, 13'd2, 13'd1}},
    '{OP_LEFT,   8'h00, 12'h000, 1'b1, '{STAT_DONE,     8'h00, 13'd2, 13'd0}},
    '{OP_LEFT,   8'h00, 12'h000, 1'b1, '{STAT_BOUNDARY, 8'h00, 13'd2, 13'd0}},
    '{OP_BACK,   8'h00, 12'h000, 1'b1, '{STAT_BOUNDARY, 8'h00, 13'd2, 13'd0}},
    '{OP_READ,   8'h00, 12'h000, 1'b1, '{STAT_DONE,     8'h00, 13'd2, 13'd0}},
    '{OP_READ,   8'h00, 12'h001, 1'b1, '{STAT_DONE,     8'hFF, 13'd2, 13'd0}},
    '{OP_RIGHT,  8'h00, 12'h000, 1'b0, '0},
    '{OP_INSERT, 8'h5A, 12'h000, 1'b0, '0},
    '{OP_READ,   8'h00, 12'h001, 1'b0, '0},
    '{OP_BACK,   8'h00, 12'h000, 1'b0, '0},
    '{OP_RIGHT,  8'h00, 12'h000, 1'b0, '0},
    '{OP_RIGHT,  8'h00, 12'h000, 1'b0, '0}
  };

  initial begin
    int n;
    int unsigned cur;
    // Hold reset, then release it on a falling edge.
    repeat (ResetCyc) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      apply_edit(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].idx,
                 directed_rows[i].typed, directed_rows[i].res);

    // Random editing; a quarter of every hundred edits runs with no idling.
    // Now and then type a short word and read it back just left of the cursor.
    n = 0;
    while (n < RandomOps) begin
      idle_on = (n % 100) < 75;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(3, 12)) begin
          apply_edit(OP_INSERT, CharW'($urandom_range(8'h20, 8'h7E)), '0);
          n++;
        end
        cur = left_n;
        for (int k = 8; k > 0; k--) begin
          if (cur >= k) begin
            apply_edit(OP_READ, '0, IndexW'(cur - k));
            n++;
          end
        end
      end else begin
        random_edit();
        n++;
      end
    end

    // Let the output side empty before the sender carries on.
    idle_on = 1'b1;
    wait_drained();

    // Probe the far index, both ends of the text and the moves around the
    // cursor.
    apply_edit(OP_INSERT, 8'hFF, '0);
    apply_edit(OP_INSERT, 8'h00, '0);
    apply_edit(OP_READ, '0, 12'hFFF);
    apply_edit(OP_READ, '0, 12'h000);
    apply_edit(OP_READ, '0, IndexW'(left_n));
    apply_edit(OP_LEFT, '0, '0);
    apply_edit(OP_RIGHT, '0, '0);
    apply_edit(OP_BACK, '0, '0);
    apply_edit(OP_INSERT, 8'hC3, '0);
    apply_edit(OP_INSERT, 8'h3C, '0);
    apply_edit(OP_READ, '0, IndexW'(left_n - 1));

    // Closing stretch at full rate on both sides.
    idle_on = 1'b0;
    repeat (FinalOps) random_edit();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("[cursor_text_gap_buffer] OK");
    else
      $display("[cursor_text_gap_buffer] ERROR");
    $finish;
  end

endmodule
